// File: src/dltst_pkg.sv
// Shared types and constants for the display line timing and status block.
package dltst_pkg;

  localparam int LineW   = 9;
  localparam int StatusW = 16;
  localparam int NumCpu  = 2;

  // Beat layouts
  localparam int InDataW  = 32;
  localparam int InUserW  = 3;
  localparam int OutDataW = 56;

  // Config APB
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam logic [ApbAddrW-1:0] RegLegacyModeAddr = 3'd0;

  localparam logic [StatusW-1:0] WritableBits = 16'hFFB8;

  localparam logic [LineW-1:0] NormVisible = 9'd192;
  localparam logic [LineW-1:0] NormLast    = 9'd262;
  localparam logic [LineW-1:0] NormFrame   = 9'd263;
  localparam logic [LineW-1:0] LegVisible  = 9'd160;
  localparam logic [LineW-1:0] LegLast     = 9'd227;
  localparam logic [LineW-1:0] LegFrame    = 9'd228;

  // Status word bit positions
  localparam int BitVbl      = 0;
  localparam int BitHbl      = 1;
  localparam int BitMatch    = 2;
  localparam int BitVblEn    = 3;
  localparam int BitHblEn    = 4;
  localparam int BitMatchEn  = 5;
  localparam int BitCmpHigh  = 7;

  typedef enum logic [1:0] {
    REQ_HBLANK    = 2'd0,
    REQ_LINE_END  = 2'd1,
    REQ_STAT_WR   = 2'd2,
    REQ_NONE      = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t           req_type;
    logic                cpu_select;
    logic [StatusW-1:0]  write_mask;
    logic [StatusW-1:0]  write_value;
  } event_t;

  typedef struct packed {
    logic [NumCpu-1:0] irq_hblank;
    logic [NumCpu-1:0] irq_vblank;
    logic [NumCpu-1:0] irq_line_match;
    logic [NumCpu-1:0] dma_hblank;
    logic [NumCpu-1:0] dma_vblank;
    logic              frame_end;
  } pulses_t;

endpackage

// File: src/display_line_timing_status.sv
// Top level of the display line timing and status block.
// Flow: an accepted event beat waits in the input register, then loads the
//   result register when that register is free or being drained.
// Throughput: one event per cycle while m_tready does not hold the result
//   stream; the line counter and status words are updated in the single
//   evaluation pass between the two registers.
// Reset (rst, synchronous): line counter, both status words, legacy mode and
//   both valid flags cleared.
module display_line_timing_status (
  input  logic                                clk,
  input  logic                                rst,
  // event stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [dltst_pkg::InDataW-1:0]       s_tdata,  // write_mask, write_value
  input  logic [dltst_pkg::InUserW-1:0]       s_tuser,  // req_type, cpu_select
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // status_cpu0, status_cpu1, line_count, irq_hblank, irq_vblank,
  // irq_line_match, dma_hblank, dma_vblank, frame_end, zero pad
  output logic [dltst_pkg::OutDataW-1:0]      m_tdata,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dltst_pkg::ApbAddrW-1:0]      paddr,
  input  logic [dltst_pkg::ApbDataW-1:0]      pwdata,
  output logic [dltst_pkg::ApbDataW-1:0]      prdata,
  output logic                                pready
);
  import dltst_pkg::*;

  logic legacy_mode;

  // input register
  logic   in_valid;
  event_t in_ev;

  // timing state
  logic [LineW-1:0]                line_counter;
  logic [NumCpu-1:0][StatusW-1:0]  status_words;
  logic [LineW-1:0]                line_counter_next;
  logic [NumCpu-1:0][StatusW-1:0]  status_words_next;
  pulses_t                         pulses_next;

  // result register
  logic                  out_valid;
  logic [OutDataW-1:0]   out_data;

  logic advance;

  // Event moves on when the result register is free or being drained;
  // the input register refills in the same cycle.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  dltst_apb u_apb (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .legacy_mode (legacy_mode)
  );

  dltst_eval u_eval (
    .legacy_mode (legacy_mode),
    .ev          (in_ev),
    .line_cur    (line_counter),
    .stat_cur    (status_words),
    .line_new    (line_counter_next),
    .stat_new    (status_words_next),
    .pulses      (pulses_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_ev.req_type    <= req_type_t'(s_tuser[1:0]);
      in_ev.cpu_select  <= s_tuser[2];
      in_ev.write_mask  <= s_tdata[15:0];
      in_ev.write_value <= s_tdata[31:16];
    end
  end

  // State only moves when an event is committed to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_counter <= '0;
      status_words <= '0;
    end else if (advance) begin
      line_counter <= line_counter_next;
      status_words <= status_words_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {4'b0000,
                   pulses_next.frame_end,
                   pulses_next.dma_vblank,
                   pulses_next.dma_hblank,
                   pulses_next.irq_line_match,
                   pulses_next.irq_vblank,
                   pulses_next.irq_hblank,
                   line_counter_next,
                   status_words_next[1],
                   status_words_next[0]};
    end
  end

endmodule

// File: src/dltst_apb.sv
// APB register port holding the legacy mode bit.
module dltst_apb (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dltst_pkg::ApbAddrW-1:0]    paddr,
  input  logic [dltst_pkg::ApbDataW-1:0]    pwdata,
  output logic [dltst_pkg::ApbDataW-1:0]    prdata,
  output logic                              pready,
  output logic                              legacy_mode
);
  import dltst_pkg::*;

  logic sel_legacy;

  // Word decode only; byte offset bits ignored
  assign sel_legacy = (paddr[ApbAddrW-1:2] == RegLegacyModeAddr[ApbAddrW-1:2]);
  assign pready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      legacy_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && sel_legacy) begin
      legacy_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_legacy) begin
      prdata = {{(ApbDataW-1){1'b0}}, legacy_mode};
    end
  end

endmodule

// File: src/dltst_eval.sv
// Event evaluation: next line counter, next status words and pulses.
module dltst_eval (
  input  logic                                              legacy_mode,
  input  dltst_pkg::event_t                                 ev,
  input  logic [dltst_pkg::LineW-1:0]                       line_cur,
  input  logic [dltst_pkg::NumCpu-1:0][dltst_pkg::StatusW-1:0] stat_cur,
  output logic [dltst_pkg::LineW-1:0]                       line_new,
  output logic [dltst_pkg::NumCpu-1:0][dltst_pkg::StatusW-1:0] stat_new,
  output dltst_pkg::pulses_t                                pulses
);
  import dltst_pkg::*;

  logic [LineW-1:0]  visible;
  logic [LineW-1:0]  last_line;
  logic [LineW-1:0]  frame_len;
  logic [LineW-1:0]  line_inc;
  logic [LineW-1:0]  cmp_line [NumCpu];
  logic [NumCpu-1:0] active;
  logic [StatusW-1:0] wmask;

  assign visible   = legacy_mode ? LegVisible : NormVisible;
  assign last_line = legacy_mode ? LegLast    : NormLast;
  assign frame_len = legacy_mode ? LegFrame   : NormFrame;
  assign line_inc  = line_cur + LineW'(1);
  // legacy mode drives CPU 1 only
  assign active    = legacy_mode ? 2'b10 : 2'b11;
  assign wmask     = ev.write_mask & WritableBits;

  always_comb begin
    line_new = line_cur;
    stat_new = stat_cur;
    pulses   = '0;
    for (int i = 0; i < NumCpu; i++) begin
      cmp_line[i] = '0;
    end

    case (ev.req_type)
      REQ_HBLANK: begin
        if (line_cur < visible) begin
          pulses.dma_hblank = legacy_mode ? 2'b10 : 2'b01;
        end
        for (int i = 0; i < NumCpu; i++) begin
          if (active[i]) begin
            stat_new[i][BitHbl]  = 1'b1;
            pulses.irq_hblank[i] = stat_cur[i][BitHblEn];
          end
        end
      end

      REQ_LINE_END: begin
        line_new = line_inc;
        if (line_inc == visible) begin
          pulses.frame_end = 1'b1;
          for (int i = 0; i < NumCpu; i++) begin
            if (active[i]) begin
              stat_new[i][BitVbl]  = 1'b1;
              pulses.irq_vblank[i] = stat_cur[i][BitVblEn];
              pulses.dma_vblank[i] = 1'b1;
            end
          end
        end else if (line_inc == last_line) begin
          for (int i = 0; i < NumCpu; i++) begin
            if (active[i]) begin
              stat_new[i][BitVbl] = 1'b0;
            end
          end
        end else if (line_inc >= frame_len) begin
          line_new = '0;
        end
        for (int i = 0; i < NumCpu; i++) begin
          cmp_line[i] = {stat_cur[i][BitCmpHigh] & ~legacy_mode, stat_cur[i][15:8]};
          if (active[i]) begin
            stat_new[i][BitHbl]      = 1'b0;
            stat_new[i][BitMatch]    = (line_new == cmp_line[i]);
            pulses.irq_line_match[i] = (line_new == cmp_line[i]) &&
                                       stat_cur[i][BitMatchEn];
          end
        end
      end

      REQ_STAT_WR: begin
        stat_new[ev.cpu_select] = (stat_cur[ev.cpu_select] & ~wmask) |
                                  (ev.write_value & wmask);
      end

      default: begin
      end
    endcase
  end

endmodule
